/* hw/rtl/dcp_pkg.sv */
// dcp_pkg: shared types, stage map and helpers for the distance constraint core
// depends on nothing; imported by distance_constraint_projection_core
`default_nettype none

package dcp_pkg;

  // fixed point format of positions, masses and multiplier
  localparam int FRAC_BITS = 16;
  // unit direction is Q1.30
  localparam int NRM_SH    = 30;
  localparam int NRM_W     = NRM_SH + 1;
  localparam logic [NRM_W-1:0] NRM_ONE = NRM_W'(1) << NRM_SH;

  // correction amount and its split for the direction multiply
  localparam int AMT_W = 64 - FRAC_BITS;
  localparam int LO_W  = AMT_W / 2;
  localparam int HI_W  = AMT_W - LO_W;
  localparam int SAT_W = AMT_W + 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [16:0] STIFF_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOLVER_MODE = 2'd0,
    CFG_STIFFNESS   = 2'd1,
    CFG_COMPLIANCE  = 2'd2
  } cfg_idx_e;

  // pipeline stage map (register index of each step)
  localparam int ST_IN      = 0;
  localparam int ST_V       = ST_IN + 1;
  localparam int ST_SQ      = ST_V + 1;
  localparam int ST_SUM     = ST_SQ + 1;
  localparam int RT_STEPS   = 33;
  localparam int ST_RT0     = ST_SUM + 1;
  localparam int ST_RT_LAST = ST_SUM + RT_STEPS;
  localparam int ST_C       = ST_RT_LAST + 1;
  localparam int ST_M       = ST_C + 1;
  localparam int ST_BIG     = ST_M + 1;
  localparam int DV_STEPS   = 32;
  localparam int ST_DV0     = ST_BIG + 1;
  localparam int ST_DV_LAST = ST_BIG + DV_STEPS;
  localparam int ST_Q       = ST_DV_LAST + 1;
  localparam int ST_AMT     = ST_Q + 1;
  localparam int ST_PP      = ST_AMT + 1;
  localparam int ST_MV      = ST_PP + 1;
  localparam int ST_OUT     = ST_MV + 1;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic        [31:0] first_inv_mass;
    logic        [31:0] second_inv_mass;
    logic        [30:0] rest_len;
    logic signed [31:0] multiplier_in;
  } dcp_item_t;

  typedef struct packed {
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_first_z;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic signed [31:0] new_second_z;
    logic signed [31:0] multiplier_out;
    logic               degenerate;
  } dcp_result_t;

  // saturate a wide signed value to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [31:0] r;
    if (!v[SAT_W-1] && (v[SAT_W-2:31] != '0)) begin
      r = 32'h7fff_ffff;
    end else if (v[SAT_W-1] && (v[SAT_W-2:31] != '1)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/distance_constraint_projection_core.sv */
// distance_constraint_projection_core: pipelined two-particle distance constraint
// depends on dcp_pkg (types, stage map, saturation helper)
//
// Usage:
//   - input channel: an item is taken at a rising edge with start_i high and
//     busy_o low; busy_o is low at all times except the first cycle after reset,
//     so one constraint can enter every cycle
//   - result channel: result_valid_o marks result_o for exactly one cycle; the
//     receiver has no way to hold it, so the block never stalls
//   - configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//     (0 solver mode, 1 stiffness, 2 scaled compliance); writes to other
//     indexes are dropped; write only while no item is in flight
//   - throughput is one item per cycle
//   - the length comes from a 33 step bit-serial square root, followed by
//     32 step restoring dividers for the unit direction and the extended
//     multiplier step, each step one register stage
//   - reset clears all valid bits and loads the register defaults (plain mode,
//     stiffness one, compliance zero); items in flight are dropped
`default_nettype none

module distance_constraint_projection_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  dcp_pkg::dcp_item_t           item_i,
  output logic                         result_valid_o,
  output dcp_pkg::dcp_result_t         result_o,
  input  wire                          cfg_we_i,
  input  wire [dcp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [dcp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dcp_pkg::*;

  // per item context that travels down the pipe
  typedef struct packed {
    logic [2:0][31:0]  p0;
    logic [2:0][31:0]  p1;
    logic [2:0]        vneg;
    logic [2:0][32:0]  vmag;
    logic [31:0]       w0;
    logic [31:0]       w1;
    logic [31:0]       lam;
    logic [31:0]       lmag;
    logic [30:0]       rest;
    logic [32:0]       ws;
    logic [33:0]       den;
    logic [63:0]       m2;
    logic [32:0]       cmag;
    logic              cpos;
    logic              cnn;
    logic              degen;
    logic [32:0]       dd;
    logic [32:0]       g0;
    logic [32:0]       g1;
    logic [65:0]       pc0;
    logic [65:0]       pc1;
    logic [63:0]       m;
    logic              nn;
    logic              big;
    logic [32:0]       pamt0;
    logic [32:0]       pamt1;
    logic [31:0]       q;
    logic [31:0]       lamo;
    logic [2:0][NRM_W-1:0] nrm;
    logic [AMT_W-1:0]  amt0;
    logic [AMT_W-1:0]  amt1;
    logic              neg;
  } ctx_t;

  localparam int FW = AMT_W + 31;

  // configuration registers
  logic        mode_q;
  logic [16:0] stiff_q;
  logic [31:0] comp_q;
  logic        busy_q;
  logic        accept;

  logic [ST_OUT:0] vld_q;
  ctx_t            ctx_d [0:ST_MV];
  ctx_t            ctx_q [0:ST_MV];

  // arithmetic scratch registers
  logic [2:0][65:0]  sq_q;
  logic [65:0]       rrem_q [ST_SUM:ST_RT_LAST];
  logic [32:0]       root_q [ST_SUM:ST_RT_LAST];
  logic [1:0][64:0]  grem_q [ST_SUM:ST_RT_LAST];
  logic [1:0][32:0]  gquo_q [ST_SUM:ST_RT_LAST];
  logic [2:0][62:0]  nrem_q [ST_BIG:ST_DV_LAST];
  logic [2:0][31:0]  nquo_q [ST_BIG:ST_DV_LAST];
  logic [63:0]       qrem_q [ST_BIG:ST_DV_LAST];
  logic [31:0]       qquo_q [ST_BIG:ST_DV_LAST];
  logic [1:0][2:0][LO_W+30:0] pplo_q;
  logic [1:0][2:0][HI_W+30:0] pphi_q;
  logic [1:0][2:0][AMT_W-1:0] mv_q;
  dcp_result_t       res_d;
  dcp_result_t       res_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      stiff_q <= STIFF_ONE;
      comp_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SOLVER_MODE: mode_q <= cfg_data_i[0];
        CFG_STIFFNESS:   stiff_q <= (cfg_data_i[16:0] > STIFF_ONE) ? STIFF_ONE
                                                                   : cfg_data_i[16:0];
        CFG_COMPLIANCE:  comp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input handshake and valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[ST_OUT-1:0], accept};
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_d;
  end

  // load item
  always_comb begin
    ctx_d[ST_IN]      = '0;
    ctx_d[ST_IN].p0   = {item_i.first_z, item_i.first_y, item_i.first_x};
    ctx_d[ST_IN].p1   = {item_i.second_z, item_i.second_y, item_i.second_x};
    ctx_d[ST_IN].w0   = item_i.first_inv_mass;
    ctx_d[ST_IN].w1   = item_i.second_inv_mass;
    ctx_d[ST_IN].rest = item_i.rest_len;
    ctx_d[ST_IN].lam  = item_i.multiplier_in;
  end

  for (genvar k = 1; k <= ST_MV; k++) begin : g_st
    if (k == ST_V) begin : g_v
      // separation, its magnitude, mass sum, multiplier magnitude
      always_comb begin : c_v
        logic signed [32:0] df;
        ctx_d[k] = ctx_q[k-1];
        for (int i = 0; i < 3; i++) begin
          df = $signed({ctx_q[k-1].p0[i][31], ctx_q[k-1].p0[i]})
             - $signed({ctx_q[k-1].p1[i][31], ctx_q[k-1].p1[i]});
          ctx_d[k].vneg[i] = df[32];
          ctx_d[k].vmag[i] = df[32] ? 33'(-df) : 33'(df);
        end
        ctx_d[k].ws   = 33'(ctx_q[k-1].w0) + 33'(ctx_q[k-1].w1);
        ctx_d[k].lmag = ctx_q[k-1].lam[31] ? 32'(-ctx_q[k-1].lam) : ctx_q[k-1].lam;
      end
    end else if (k == ST_SQ) begin : g_sq
      // squares, compliance times multiplier, extended denominator
      always_comb begin
        ctx_d[k]     = ctx_q[k-1];
        ctx_d[k].m2  = comp_q * ctx_q[k-1].lmag;
        ctx_d[k].den = 34'(ctx_q[k-1].ws) + 34'(comp_q);
      end
      always_ff @(posedge clk_i) begin
        for (int i = 0; i < 3; i++) begin
          sq_q[i] <= ctx_q[k-1].vmag[i] * ctx_q[k-1].vmag[i];
        end
      end
    end else if (k == ST_SUM) begin : g_sum
      // squared length, seed root and weight dividers
      always_comb ctx_d[k] = ctx_q[k-1];
      always_ff @(posedge clk_i) begin
        rrem_q[k]    <= sq_q[0] + sq_q[1] + sq_q[2];
        root_q[k]    <= '0;
        grem_q[k][0] <= 65'({ctx_q[k-1].w0, 32'b0});
        grem_q[k][1] <= 65'({ctx_q[k-1].w1, 32'b0});
        gquo_q[k]    <= '0;
      end
    end else if (k >= ST_RT0 && k <= ST_RT_LAST) begin : g_rt
      // one root bit and one weight quotient bit per stage
      localparam int B = ST_RT_LAST - k;
      logic [65:0]      trial;
      logic [65:0]      rem_d;
      logic [32:0]      root_d;
      logic [65:0]      wsh;
      logic [1:0][64:0] grem_d;
      logic [1:0][32:0] gquo_d;
      always_comb begin
        ctx_d[k] = ctx_q[k-1];
        trial    = (66'(root_q[k-1]) << (B + 1)) | (66'(1) << (2 * B));
        rem_d    = rrem_q[k-1];
        root_d   = root_q[k-1];
        if (rrem_q[k-1] >= trial) begin
          rem_d  = rrem_q[k-1] - trial;
          root_d = root_q[k-1] | (33'(1) << B);
        end
        wsh    = 66'(ctx_q[k-1].ws) << B;
        grem_d = grem_q[k-1];
        gquo_d = gquo_q[k-1];
        for (int i = 0; i < 2; i++) begin
          if ({1'b0, grem_q[k-1][i]} >= wsh) begin
            grem_d[i]    = 65'({1'b0, grem_q[k-1][i]} - wsh);
            gquo_d[i][B] = 1'b1;
          end
        end
      end
      always_ff @(posedge clk_i) begin
        rrem_q[k] <= rem_d;
        root_q[k] <= root_d;
        grem_q[k] <= grem_d;
        gquo_q[k] <= gquo_d;
      end
    end else if (k == ST_C) begin : g_c
      // constraint value and flags
      always_comb begin : c_c
        logic [32:0]        d;
        logic signed [33:0] c;
        ctx_d[k]       = ctx_q[k-1];
        d              = root_q[k-1];
        c              = $signed({1'b0, d}) - $signed({3'b0, ctx_q[k-1].rest});
        ctx_d[k].cmag  = c[33] ? 33'(-c) : 33'(c);
        ctx_d[k].cpos  = !c[33] && (c != '0);
        ctx_d[k].cnn   = !c[33];
        ctx_d[k].degen = (d == '0) || (ctx_q[k-1].ws == '0);
        ctx_d[k].dd    = (d == '0) ? 33'd1 : d;
        ctx_d[k].g0    = gquo_q[k-1][0];
        ctx_d[k].g1    = gquo_q[k-1][1];
      end
    end else if (k == ST_M) begin : g_m
      // extended numerator magnitude and sign, plain weighted products
      always_comb begin : c_m
        logic [63:0] m1;
        logic        n2;
        ctx_d[k]     = ctx_q[k-1];
        m1           = 64'(ctx_q[k-1].cmag) << FRAC_BITS;
        n2           = !ctx_q[k-1].lam[31] && (ctx_q[k-1].lam != '0);
        if (ctx_q[k-1].cpos == n2) begin
          ctx_d[k].m  = m1 + ctx_q[k-1].m2;
          ctx_d[k].nn = ctx_q[k-1].cpos;
        end else if (m1 >= ctx_q[k-1].m2) begin
          ctx_d[k].m  = m1 - ctx_q[k-1].m2;
          ctx_d[k].nn = ctx_q[k-1].cpos;
        end else begin
          ctx_d[k].m  = ctx_q[k-1].m2 - m1;
          ctx_d[k].nn = n2;
        end
        ctx_d[k].pc0 = ctx_q[k-1].cmag * ctx_q[k-1].g0;
        ctx_d[k].pc1 = ctx_q[k-1].cmag * ctx_q[k-1].g1;
      end
    end else if (k == ST_BIG) begin : g_big
      // quotient range check, stiffness scaling, seed dividers
      always_comb begin : c_big
        logic [50:0] sp0;
        logic [50:0] sp1;
        ctx_d[k]       = ctx_q[k-1];
        ctx_d[k].big   = {2'b0, ctx_q[k-1].m} >= {ctx_q[k-1].den, 32'b0};
        sp0            = ctx_q[k-1].pc0[65:32] * stiff_q;
        sp1            = ctx_q[k-1].pc1[65:32] * stiff_q;
        ctx_d[k].pamt0 = sp0[48:16];
        ctx_d[k].pamt1 = sp1[48:16];
      end
      always_ff @(posedge clk_i) begin
        for (int i = 0; i < 3; i++) begin
          nrem_q[k][i] <= {ctx_q[k-1].vmag[i], 30'b0};
        end
        nquo_q[k] <= '0;
        qrem_q[k] <= ctx_q[k-1].m;
        qquo_q[k] <= '0;
      end
    end else if (k >= ST_DV0 && k <= ST_DV_LAST) begin : g_dv
      // one quotient bit per stage for direction and multiplier step
      localparam int J = ST_DV_LAST - k;
      logic [63:0]      nd;
      logic [64:0]      qd;
      logic [2:0][62:0] nrem_d;
      logic [2:0][31:0] nquo_d;
      logic [63:0]      qrem_d;
      logic [31:0]      qquo_d;
      always_comb begin
        ctx_d[k] = ctx_q[k-1];
        nd       = 64'(ctx_q[k-1].dd) << J;
        qd       = 65'(ctx_q[k-1].den) << J;
        nrem_d   = nrem_q[k-1];
        nquo_d   = nquo_q[k-1];
        qrem_d   = qrem_q[k-1];
        qquo_d   = qquo_q[k-1];
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, nrem_q[k-1][i]} >= nd) begin
            nrem_d[i]    = 63'({1'b0, nrem_q[k-1][i]} - nd);
            nquo_d[i][J] = 1'b1;
          end
        end
        if ({1'b0, qrem_q[k-1]} >= qd) begin
          qrem_d    = 64'({1'b0, qrem_q[k-1]} - qd);
          qquo_d[J] = 1'b1;
        end
      end
      always_ff @(posedge clk_i) begin
        nrem_q[k] <= nrem_d;
        nquo_q[k] <= nquo_d;
        qrem_q[k] <= qrem_d;
        qquo_q[k] <= qquo_d;
      end
    end else if (k == ST_Q) begin : g_q
      // clamp multiplier step and update multiplier
      always_comb begin : c_q
        logic [32:0]             qv;
        logic [31:0]             qc;
        logic signed [SAT_W-1:0] qx;
        logic signed [SAT_W-1:0] ls;
        ctx_d[k] = ctx_q[k-1];
        qv = ctx_q[k-1].big ? 33'h1_0000_0000 : {1'b0, qquo_q[k-1]};
        if (ctx_q[k-1].nn) begin
          qc = (qv > 33'h0_8000_0000) ? 32'h8000_0000 : qv[31:0];
        end else begin
          qc = (qv > 33'h0_7fff_ffff) ? 32'h7fff_ffff : qv[31:0];
        end
        qx = $signed(SAT_W'(qc));
        ls = $signed({{(SAT_W-32){ctx_q[k-1].lam[31]}}, ctx_q[k-1].lam})
           + (ctx_q[k-1].nn ? -qx : qx);
        ctx_d[k].q    = qc;
        ctx_d[k].lamo = (mode_q && (ctx_q[k-1].den != '0)) ? sat32(ls) : ctx_q[k-1].lam;
        for (int i = 0; i < 3; i++) begin
          ctx_d[k].nrm[i] = nquo_q[k-1][i][NRM_W-1:0];
        end
      end
    end else if (k == ST_AMT) begin : g_amt
      // correction amount per particle
      always_comb begin : c_amt
        logic [63:0] e0;
        logic [63:0] e1;
        ctx_d[k] = ctx_q[k-1];
        e0 = ctx_q[k-1].q * ctx_q[k-1].w0;
        e1 = ctx_q[k-1].q * ctx_q[k-1].w1;
        if (!mode_q) begin
          if (ctx_q[k-1].ws != '0) begin
            ctx_d[k].amt0 = AMT_W'(ctx_q[k-1].pamt0);
            ctx_d[k].amt1 = AMT_W'(ctx_q[k-1].pamt1);
            ctx_d[k].neg  = ctx_q[k-1].cnn;
          end else begin
            ctx_d[k].amt0 = '0;
            ctx_d[k].amt1 = '0;
            ctx_d[k].neg  = 1'b0;
          end
        end else if (ctx_q[k-1].den != '0) begin
          ctx_d[k].amt0 = AMT_W'(e0 >> FRAC_BITS);
          ctx_d[k].amt1 = AMT_W'(e1 >> FRAC_BITS);
          ctx_d[k].neg  = ctx_q[k-1].nn;
        end else begin
          ctx_d[k].amt0 = '0;
          ctx_d[k].amt1 = '0;
          ctx_d[k].neg  = 1'b0;
        end
      end
    end else if (k == ST_PP) begin : g_pp
      // partial products of amount times direction
      always_comb ctx_d[k] = ctx_q[k-1];
      always_ff @(posedge clk_i) begin
        for (int i = 0; i < 3; i++) begin
          pplo_q[0][i] <= ctx_q[k-1].amt0[LO_W-1:0] * ctx_q[k-1].nrm[i];
          pphi_q[0][i] <= ctx_q[k-1].amt0[AMT_W-1:LO_W] * ctx_q[k-1].nrm[i];
          pplo_q[1][i] <= ctx_q[k-1].amt1[LO_W-1:0] * ctx_q[k-1].nrm[i];
          pphi_q[1][i] <= ctx_q[k-1].amt1[AMT_W-1:LO_W] * ctx_q[k-1].nrm[i];
        end
      end
    end else if (k == ST_MV) begin : g_mv
      // combine partials into move magnitudes
      logic [1:0][2:0][FW-1:0] full;
      always_comb begin
        ctx_d[k] = ctx_q[k-1];
        for (int p = 0; p < 2; p++) begin
          for (int i = 0; i < 3; i++) begin
            full[p][i] = (FW'(pphi_q[p][i]) << LO_W) + FW'(pplo_q[p][i]);
          end
        end
      end
      always_ff @(posedge clk_i) begin
        for (int p = 0; p < 2; p++) begin
          for (int i = 0; i < 3; i++) begin
            mv_q[p][i] <= full[p][i][AMT_W+NRM_SH-1:NRM_SH];
          end
        end
      end
    end else begin : g_pass
      always_comb ctx_d[k] = ctx_q[k-1];
    end
  end

  // apply moves and saturate
  always_comb begin : c_out
    logic                    s;
    logic signed [SAT_W-1:0] m0;
    logic signed [SAT_W-1:0] m1;
    logic [2:0][31:0]        n0;
    logic [2:0][31:0]        n1;
    for (int i = 0; i < 3; i++) begin
      s  = ctx_q[ST_MV].neg ^ ctx_q[ST_MV].vneg[i];
      m0 = $signed(SAT_W'(mv_q[0][i]));
      m1 = $signed(SAT_W'(mv_q[1][i]));
      n0[i] = sat32($signed({{(SAT_W-32){ctx_q[ST_MV].p0[i][31]}}, ctx_q[ST_MV].p0[i]})
                    + (s ? -m0 : m0));
      n1[i] = sat32($signed({{(SAT_W-32){ctx_q[ST_MV].p1[i][31]}}, ctx_q[ST_MV].p1[i]})
                    + (s ? m1 : -m1));
    end
    res_d.new_first_x    = n0[0];
    res_d.new_first_y    = n0[1];
    res_d.new_first_z    = n0[2];
    res_d.new_second_x   = n1[0];
    res_d.new_second_y   = n1[1];
    res_d.new_second_z   = n1[2];
    res_d.multiplier_out = ctx_q[ST_MV].lamo;
    res_d.degenerate     = ctx_q[ST_MV].degen;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o       = res_q;
  assign result_valid_o = vld_q[ST_OUT];

  // every result traces back to an item taken a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, ST_OUT + 1))
    else $error("result without matching item");

  // plain mode leaves the multiplier untouched
  a_plain_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !mode_q) |->
      (result_o.multiplier_out == $past(item_i.multiplier_in, ST_OUT + 1)))
    else $error("multiplier changed in plain mode");

  // clamped multiplier step never exceeds 2^31
  a_q_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_Q] |-> (ctx_q[ST_Q].q <= 32'h8000_0000))
    else $error("multiplier step out of range");

  // unit direction components stay at or below one
  a_nrm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_Q] |-> ((ctx_q[ST_Q].nrm[0] <= NRM_ONE) && (ctx_q[ST_Q].nrm[1] <= NRM_ONE)
                     && (ctx_q[ST_Q].nrm[2] <= NRM_ONE)))
    else $error("direction component above one");

endmodule

`default_nettype wire
